/* hdl/bldc_six_step_commutator_assert.svh */
// Assertion macros for the six-step commutator checker.
// No dependencies; included by the checker file only.
`ifndef BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH
`define BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH

// Property on the rising clock edge, masked while reset is high.
`define BSSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property on the rising clock edge that also holds during reset.
`define BSSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bssc_pkg.sv */
// Shared types, constants and step tables for the six-step commutator.
// No dependencies; used by bssc_core and bldc_six_step_commutator.
package bssc_pkg;

   localparam int STEP_W     = 3;
   localparam int MASK_W     = 3;
   localparam int QCOUNT_W   = 11;
   localparam int BUMP_W     = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [STEP_W-1:0]   STEP_LAST   = 3'd5;
   localparam logic [QCOUNT_W-1:0] QCOUNT_MAX  = 11'h7FF;
   localparam logic [BUMP_W-1:0]   BUMP_RESET  = 16'd250;
   localparam logic [MASK_W-1:0]   PWM_RESET   = 3'b111;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUMP    = 1'b1;

   typedef enum logic [1:0] {
      PH_A = 2'd0,
      PH_B = 2'd1,
      PH_C = 2'd2
   } phase_type;

   typedef struct packed {
      logic [QCOUNT_W-1:0] fall_qualify_ticks;
      logic [QCOUNT_W-1:0] rise_qualify_ticks;
      logic                motor_running;
      logic [2:0]          comparators;   // bit0 A, bit1 B, bit2 C
   } req_item_type;

   typedef struct packed {
      logic              bumped;
      logic              commutated;
      logic              watch_rising;
      logic [1:0]        watch_phase;
      logic [MASK_W-1:0] pwm_enable_mask;
      logic [MASK_W-1:0] gate_pin_mask;
      logic [STEP_W-1:0] step_index;
   } rsp_item_type;

   function automatic logic [STEP_W-1:0] power_step(logic [STEP_W-1:0] cnt, logic rev);
      return rev ? STEP_LAST - cnt : cnt;
   endfunction

   // rising on even steps going forward, on odd steps in reverse
   function automatic logic step_rising(logic [STEP_W-1:0] s, logic rev);
      return ~s[0] ^ rev;
   endfunction

   function automatic phase_type float_phase(logic [STEP_W-1:0] s);
      phase_type p;
      case (s)
         3'd0: p = PH_B;
         3'd1: p = PH_A;
         3'd2: p = PH_C;
         3'd3: p = PH_B;
         3'd4: p = PH_A;
         3'd5: p = PH_C;
         default: p = PH_A;
      endcase
      return p;
   endfunction

   function automatic phase_type low_phase(logic [STEP_W-1:0] s);
      phase_type p;
      case (s)
         3'd0, 3'd1: p = PH_C;
         3'd2, 3'd3: p = PH_A;
         3'd4, 3'd5: p = PH_B;
         default: p = PH_A;
      endcase
      return p;
   endfunction

   function automatic phase_type high_phase(logic [STEP_W-1:0] s);
      phase_type p;
      case (s)
         3'd0, 3'd5: p = PH_A;
         3'd1, 3'd2: p = PH_B;
         3'd3, 3'd4: p = PH_C;
         default: p = PH_A;
      endcase
      return p;
   endfunction

   function automatic logic [MASK_W-1:0] phase_bit(phase_type p);
      logic [MASK_W-1:0] m;
      case (p)
         PH_A: m = 3'b001;
         PH_B: m = 3'b010;
         PH_C: m = 3'b100;
         default: m = 3'b000;
      endcase
      return m;
   endfunction

endpackage

/* hdl/bssc_core.sv */
// Commutation state and per-tick next-state logic.
// Depends on bssc_pkg; instantiated by bldc_six_step_commutator.
module bssc_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  bssc_pkg::req_item_type       item,
   input  logic                         reverse_direction,
   input  logic [bssc_pkg::BUMP_W-1:0]  bump_ticks,
   output bssc_pkg::rsp_item_type       result
);

   logic [bssc_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [bssc_pkg::MASK_W-1:0]   gate_ff, gate_in;
   logic [bssc_pkg::MASK_W-1:0]   pwm_ff, pwm_in;
   logic                          armed_ff, armed_in;
   logic [2:0]                    last_ff, last_in;
   logic                          qual_ff, qual_in;
   logic [bssc_pkg::QCOUNT_W-1:0] qcnt_ff, qcnt_in;
   logic [bssc_pkg::BUMP_W-1:0]   bcnt_ff, bcnt_in;

   logic [bssc_pkg::STEP_W-1:0]   step_now, step_adv, step_new, step_out;
   bssc_pkg::phase_type           ph, ph_out;
   logic                          rising, lvl, prev;
   logic [bssc_pkg::QCOUNT_W-1:0] thr, qcnt_inc;
   logic [bssc_pkg::BUMP_W-1:0]   bcnt_inc;
   logic                          comm_q, bump, comm;
   logic [bssc_pkg::MASK_W-1:0]   fbit, lbit, hbit, gate_c, pwm_c;

   always_comb begin
      step_now = bssc_pkg::power_step(step_ff, reverse_direction);
      ph       = bssc_pkg::float_phase(step_now);
      rising   = bssc_pkg::step_rising(step_now, reverse_direction);
      lvl      = item.comparators[2'(ph)];
      prev     = last_ff[2'(ph)];
      thr      = rising ? item.rise_qualify_ticks : item.fall_qualify_ticks;
      qcnt_inc = (qcnt_ff == bssc_pkg::QCOUNT_MAX) ? qcnt_ff
                                                   : qcnt_ff + 11'd1;

      qual_in = qual_ff;
      qcnt_in = qcnt_ff;
      comm_q  = 1'b0;
      if (qual_ff) begin
         if (lvl != rising) begin
            qual_in = 1'b0;
            qcnt_in = '0;
         end else begin
            qcnt_in = qcnt_inc;
            comm_q  = (qcnt_inc >= thr);
         end
      end else if (armed_ff && prev != rising && lvl == rising) begin
         qual_in = 1'b1;
         qcnt_in = '0;
         comm_q  = (thr == '0);
      end

      // bump timer only runs when no edge commutation this tick
      bcnt_inc = bcnt_ff + 16'd1;
      bcnt_in  = bcnt_ff;
      bump     = 1'b0;
      if (!comm_q) begin
         bcnt_in = bcnt_inc;
         if (bcnt_inc >= bump_ticks) begin
            bcnt_in = '0;
            bump    = item.motor_running;
         end
      end
      comm = comm_q | bump;

      // mask update for the step after the advance
      step_adv = (step_ff == bssc_pkg::STEP_LAST) ? '0 : step_ff + 3'd1;
      step_new = bssc_pkg::power_step(step_adv, reverse_direction);
      fbit     = bssc_pkg::phase_bit(bssc_pkg::float_phase(step_new));
      lbit     = bssc_pkg::phase_bit(bssc_pkg::low_phase(step_new));
      hbit     = bssc_pkg::phase_bit(bssc_pkg::high_phase(step_new));
      if (bssc_pkg::step_rising(step_new, reverse_direction)) begin
         gate_c = (gate_ff | lbit) & ~fbit;
         pwm_c  = pwm_ff | fbit;
      end else begin
         gate_c = (gate_ff & ~fbit) | hbit;
         pwm_c  = pwm_ff & ~fbit;
      end

      step_in  = step_ff;
      gate_in  = gate_ff;
      pwm_in   = pwm_ff;
      armed_in = armed_ff;
      if (comm) begin
         step_in  = step_adv;
         gate_in  = gate_c;
         pwm_in   = pwm_c;
         armed_in = 1'b1;
         qual_in  = 1'b0;
         qcnt_in  = '0;
         bcnt_in  = '0;
      end
      last_in = item.comparators;

      step_out = bssc_pkg::power_step(step_in, reverse_direction);
      ph_out   = bssc_pkg::float_phase(step_out);
      result.step_index      = step_out;
      result.gate_pin_mask   = gate_in;
      result.pwm_enable_mask = pwm_in;
      result.watch_phase     = 2'(ph_out);
      result.watch_rising    = bssc_pkg::step_rising(step_out, reverse_direction);
      result.commutated      = comm;
      result.bumped          = bump;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         gate_ff  <= '0;
         pwm_ff   <= bssc_pkg::PWM_RESET;
         armed_ff <= 1'b0;
         last_ff  <= '0;
         qual_ff  <= 1'b0;
         qcnt_ff  <= '0;
         bcnt_ff  <= '0;
      end else if (step_en) begin
         step_ff  <= step_in;
         gate_ff  <= gate_in;
         pwm_ff   <= pwm_in;
         armed_ff <= armed_in;
         last_ff  <= last_in;
         qual_ff  <= qual_in;
         qcnt_ff  <= qcnt_in;
         bcnt_ff  <= bcnt_in;
      end
   end

endmodule

/* hdl/bldc_six_step_commutator.sv */
// Top level of the six-step sensorless BLDC commutator: stream ports,
// csr registers, input and result registers. Depends on bssc_pkg, bssc_core.
//
// One req beat is one timer tick: three back-EMF comparator levels, the
// running flag and the rise/fall qualification times. Every tick gives one
// rsp beat carrying the power step, gate pin and PWM enable masks, the
// watched floating phase and polarity, and commutated/bumped flags. The block
// takes one beat per clock while rsp is not stalled. A beat lands in the
// input register at the edge that accepts it, and its result is registered
// in the rsp register once the result slot is free, which raises rsp_tvalid.
// Throughput is set by the single state-update loop in bssc_core. The result
// register parts the two sides: req keeps flowing while rsp_tready is high,
// and a stalled rsp holds the input register, which backs up req_tready.
// Write csr registers (reverse_direction at index 0, bump_ticks at index 1)
// only while no tick is in flight; csr_ready is always high.
module bldc_six_step_commutator (
   input  logic                                clock,
   input  logic                                reset,
   // comparator_a[0] comparator_b[1] comparator_c[2] motor_running[3]
   // rise_qualify_ticks[14:4] fall_qualify_ticks[25:15] zero[31:26]
   input  logic [bssc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // step_index[2:0] gate_pin_mask[5:3] pwm_enable_mask[8:6]
   // watch_phase[10:9] watch_rising[11] commutated[12] bumped[13] zero[15:14]
   output logic [bssc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bssc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bssc_pkg::BUMP_W-1:0]         csr_data
);

   logic                          rev_ff;
   logic [bssc_pkg::BUMP_W-1:0]   bump_ticks_ff;

   logic                          in_valid_ff;
   bssc_pkg::req_item_type        in_item_ff, in_item_in;
   logic                          advance;

   bssc_pkg::rsp_item_type        result;
   logic                          rsp_valid_ff;
   logic [bssc_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // csr registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff        <= 1'b0;
         bump_ticks_ff <= bssc_pkg::BUMP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bssc_pkg::CSR_REVERSE: rev_ff        <= csr_data[0];
            bssc_pkg::CSR_BUMP:    bump_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register; tick is processed when the result slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_item_in.comparators        = req_tdata[2:0];
      in_item_in.motor_running      = req_tdata[3];
      in_item_in.rise_qualify_ticks = req_tdata[14:4];
      in_item_in.fall_qualify_ticks = req_tdata[25:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   bssc_core u_core (
      .clock             (clock),
      .reset             (reset),
      .step_en           (advance),
      .item              (in_item_ff),
      .reverse_direction (rev_ff),
      .bump_ticks        (bump_ticks_ff),
      .result            (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, result};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/bssc_checker.sv */
// Port-level checker for the six-step commutator, bound to the top level.
// Depends on bldc_six_step_commutator_assert.svh.
`include "bldc_six_step_commutator_assert.svh"

module bssc_checker (
   input logic        clock,
   input logic        reset,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // stalled result beat holds
   `BSSC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   // masks move only on a commutating beat
   `BSSC_ASSERT(a_mask_hold, clock, reset, (rsp_tvalid && rsp_tready) ##1 (rsp_tvalid && rsp_tready && !rsp_tdata[12]) |-> rsp_tdata[8:3] == $past(rsp_tdata[8:3]), "masks changed without commutation")

   // a bump is always a commutation
   `BSSC_ASSERT(a_bump_comm, clock, reset, rsp_tvalid && rsp_tdata[13] |-> rsp_tdata[12], "bumped without commutated")

   // nothing is presented on the cycle after reset
   `BSSC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind bldc_six_step_commutator bssc_checker u_bssc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

/* sim/tb.sv */
// Self-checking testbench for bldc_six_step_commutator: random stream traffic
// on req/rsp/csr, an in-bench commutation predictor and a result scoreboard.
// Depends on bssc_pkg and the RTL only.
`timescale 1ns / 100ps

module tb;
   import bssc_pkg::*;

   localparam int REQ_BITS   = $bits(req_item_type);
   localparam int RSP_BITS   = $bits(rsp_item_type);
   localparam int IDLE_LIMIT = 3000;   // cycles with no beat on any port
   localparam int DRAIN_WAIT = 4;      // input and result registers plus margin

   // Step tables, two bits per power step, step 0 in the low bits.
   localparam logic [11:0] FLOAT_PH = {PH_C, PH_A, PH_B, PH_C, PH_A, PH_B};
   localparam logic [11:0] LOW_PH   = {PH_B, PH_B, PH_A, PH_A, PH_C, PH_C};
   localparam logic [11:0] HIGH_PH  = {PH_A, PH_C, PH_C, PH_B, PH_B, PH_A};
   // Rising-edge steps: even steps going forward, odd steps in reverse.
   localparam logic [1:0][5:0] RISE_PATTERN = {6'b101010, 6'b010101};

   // Full commutator state plus its two csr registers.
   typedef struct packed {
      logic                rev;
      logic [BUMP_W-1:0]   bump_ticks;
      logic [STEP_W-1:0]   counter;
      logic [MASK_W-1:0]   gate;
      logic [MASK_W-1:0]   pwm;
      logic [2:0]          last_cmp;
      logic                armed;
      logic                qual;
      logic [QCOUNT_W-1:0] qcount;
      logic [BUMP_W-1:0]   bcount;
   } commutator_state_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_REVERSE;
   logic [BUMP_W-1:0]      csr_data = '0;

   bldc_six_step_commutator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // live_ctl tracks the block beat by beat as ticks are accepted;
   // plan_ctl runs ahead while stimulus is built so ticks can be aimed
   // at the phase and polarity the block is actually watching.
   commutator_state_t live_ctl, plan_ctl;
   req_item_type      tick_backlog[$];
   rsp_item_type      rsp_due[$];
   req_item_type      req_beat;

   int error_count, ticks_sent, results_seen, commutations_seen, bumps_seen;
   int csr_writes, settings_run;
   int req_gap, rsp_stall, calm_left, idle_cycles;
   int qual_plan;   // hold time aimed at for the current step

   function automatic logic [STEP_W-1:0] mapped_step(commutator_state_t st);
      return st.rev ? STEP_LAST - st.counter : st.counter;
   endfunction

   function automatic phase_type lookup_phase(logic [11:0] tab, logic [STEP_W-1:0] s);
      return phase_type'(tab[2*s +: 2]);
   endfunction

   function automatic logic rises_on(logic rev, logic [STEP_W-1:0] s);
      return RISE_PATTERN[rev][s];
   endfunction

   // One timer tick of the commutator: qualification, bump timer, step
   // advance and mask update, then the result seen after the tick.
   function automatic rsp_item_type advance_tick(inout commutator_state_t st,
                                                 input req_item_type it);
      logic [STEP_W-1:0]   s;
      phase_type           ph;
      logic                rising, lvl, prev, fire, bumped;
      logic [QCOUNT_W-1:0] thr;
      logic [MASK_W-1:0]   fmask;
      rsp_item_type        r;
      s      = mapped_step(st);
      ph     = lookup_phase(FLOAT_PH, s);
      rising = rises_on(st.rev, s);
      lvl    = it.comparators[ph];
      prev   = st.last_cmp[ph];
      thr    = rising ? it.rise_qualify_ticks : it.fall_qualify_ticks;
      fire   = 1'b0;
      bumped = 1'b0;

      if (st.qual) begin
         // level fell back before the hold time: abort
         if (lvl != rising) begin
            st.qual   = 1'b0;
            st.qcount = '0;
         end else begin
            if (st.qcount != QCOUNT_MAX)
               st.qcount = st.qcount + 1'b1;
            if (st.qcount >= thr)
               fire = 1'b1;
         end
      end else if (st.armed && prev != rising && lvl == rising) begin
         st.qual   = 1'b1;
         st.qcount = '0;
         if (thr == '0)
            fire = 1'b1;
      end

      if (!fire) begin
         st.bcount = st.bcount + 1'b1;
         if (st.bcount >= st.bump_ticks) begin
            st.bcount = '0;
            if (it.motor_running) begin
               fire   = 1'b1;
               bumped = 1'b1;
            end
         end
      end

      if (fire) begin
         st.counter = (st.counter == STEP_LAST) ? '0 : st.counter + 1'b1;
         s     = mapped_step(st);
         fmask = 3'b001 << lookup_phase(FLOAT_PH, s);
         if (rises_on(st.rev, s)) begin
            st.gate = (st.gate | (3'b001 << lookup_phase(LOW_PH, s))) & ~fmask;
            st.pwm  = st.pwm | fmask;
         end else begin
            st.gate = (st.gate & ~fmask) | (3'b001 << lookup_phase(HIGH_PH, s));
            st.pwm  = st.pwm & ~fmask;
         end
         st.armed  = 1'b1;
         st.qual   = 1'b0;
         st.qcount = '0;
         st.bcount = '0;
      end

      st.last_cmp = it.comparators;

      s = mapped_step(st);
      r.step_index      = s;
      r.gate_pin_mask   = st.gate;
      r.pwm_enable_mask = st.pwm;
      r.watch_phase     = lookup_phase(FLOAT_PH, s);
      r.watch_rising    = rises_on(st.rev, s);
      r.commutated      = fire;
      r.bumped          = bumped;
      return r;
   endfunction

   // Mostly short gaps, a few long ones, none during a calm stretch.
   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(99);
      if (calm_left > 0)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(3, 1);
      if (roll < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Hold time for the next step: zero, short, medium or long.
   function automatic int pick_qualify();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20)
         return 0;
      if (roll < 80)
         return $urandom_range(8, 1);
      if (roll < 95)
         return $urandom_range(64, 9);
      return $urandom_range(400, 100);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Queue a tick, stepping the look-ahead state; a new hold time is
   // chosen whenever the look-ahead sees a commutation.
   task automatic push_tick(input req_item_type it);
      rsp_item_type r;
      r = advance_tick(plan_ctl, it);
      if (r.commutated)
         qual_plan = pick_qualify();
      tick_backlog.push_back(it);
   endtask

   // Random ticks. Nine in ten are shaped: the watched comparator is set
   // up for an edge of the right polarity and then mostly held, with the
   // odd revert to abort qualification. The rest are plain noise.
   task automatic queue_ticks(input int count, input int run_pct);
      req_item_type      it;
      logic [STEP_W-1:0] s;
      phase_type         ph;
      logic              rising, prev, lvl;
      int                held_thr, other_thr;
      for (int n = 0; n < count; n++) begin
         it.comparators        = $urandom;
         it.motor_running      = ($urandom_range(99) < run_pct);
         it.rise_qualify_ticks = $urandom_range(2047);
         it.fall_qualify_ticks = $urandom_range(2047);
         if ($urandom_range(99) >= 10) begin
            s      = mapped_step(plan_ctl);
            ph     = lookup_phase(FLOAT_PH, s);
            rising = rises_on(plan_ctl.rev, s);
            prev   = plan_ctl.last_cmp[ph];
            if (plan_ctl.qual)
               lvl = ($urandom_range(99) < 95) ? rising : ~rising;
            else if (prev != rising)
               lvl = ($urandom_range(99) < 40) ? rising : ~rising;
            else
               lvl = ~rising;   // step back so an edge can follow
            it.comparators[ph] = lvl;
            held_thr  = ($urandom_range(99) < 85) ? qual_plan : $urandom_range(2047);
            other_thr = $urandom_range(1) ? $urandom_range(2047) : $urandom_range(15);
            it.rise_qualify_ticks = rising ? held_thr : other_thr;
            it.fall_qualify_ticks = rising ? other_thr : held_thr;
         end
         push_tick(it);
      end
   endtask

   // Wait until every tick is sent and every result has come back.
   task automatic drain_ticks();
      do
         @(posedge clock);
      while (tick_backlog.size() != 0 || req_tvalid || rsp_due.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Called at a clock edge with the block idle; ends with csr_valid low again.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [BUMP_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      if (idx == CSR_REVERSE)
         live_ctl.rev = value[0];
      else
         live_ctl.bump_ticks = value;
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Write both registers, then restart the look-ahead from the block.
   task automatic new_setting(input logic rev, input logic [BUMP_W-1:0] bump);
      write_csr(CSR_REVERSE, {{(BUMP_W-1){1'b0}}, rev});
      write_csr(CSR_BUMP, bump);
      plan_ctl = live_ctl;
      settings_run++;
   endtask

   // Driver: one tick per beat, random gaps between beats. The tick on
   // the bus is predicted at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rsp_due.push_back(advance_tick(live_ctl, req_beat));
            ticks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (tick_backlog.size() != 0) begin
               req_beat = tick_backlog.pop_front();
               req_tdata  <= {{(REQ_DATA_W-REQ_BITS){1'b0}}, req_beat};
               req_tvalid <= 1'b1;
               req_gap = pick_idle();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat against the oldest prediction and
   // stalls rsp_tready at random.
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            if (rsp_due.size() == 0) begin
               error_count++;
               $display("%0t: result beat %h with no tick outstanding, expected none",
                        $time, rsp_tdata);
            end else begin
               want = rsp_due.pop_front();
               check_field("step_index", want.step_index, got.step_index);
               check_field("gate_pin_mask", want.gate_pin_mask, got.gate_pin_mask);
               check_field("pwm_enable_mask", want.pwm_enable_mask, got.pwm_enable_mask);
               check_field("watch_phase", want.watch_phase, got.watch_phase);
               check_field("watch_rising", want.watch_rising, got.watch_rising);
               check_field("commutated", want.commutated, got.commutated);
               check_field("bumped", want.bumped, got.bumped);
               results_seen++;
               if (want.commutated)
                  commutations_seen++;
               if (want.bumped)
                  bumps_seen++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(3) == 0)
               rsp_stall = pick_idle();
         end
      end
   end

   // Watchdog on beats of any kind; also paces the calm stretches.
   always @(posedge clock) begin
      if (!reset) begin
         if (calm_left > 0)
            calm_left--;
         else if ($urandom_range(199) == 0)
            calm_left = $urandom_range(150, 40);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      req_item_type it;
      // Reset values: step 0, gate pins low, all PWM enables on, not armed.
      live_ctl            = '0;
      live_ctl.bump_ticks = BUMP_RESET;
      live_ctl.pwm        = PWM_RESET;
      plan_ctl            = live_ctl;
      qual_plan           = pick_qualify();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and alternating bit patterns right after
      // reset, where edges on any phase must be ignored (nothing armed yet)
      // and the bump timer is the only way to commutate.
      for (int i = 0; i < 20; i++) begin
         it.comparators        = 3'(i * 5);
         it.motor_running      = i[0];
         it.rise_qualify_ticks = (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : 11'h555;
         it.fall_qualify_ticks = (i % 4 == 0) ? '0 : (i % 4 == 1) ? '1 : 11'h2AA;
         push_tick(it);
      end

      // Default settings: forward, bump after 250 ticks.
      settings_run = 1;
      queue_ticks(320, 70);
      drain_ticks();

      // Reverse with the shortest bump period: a bump check on every tick.
      new_setting(1'b1, 16'd1);
      queue_ticks(200, 50);
      drain_ticks();

      // Forward with the longest bump period: only qualified crossings.
      new_setting(1'b0, '1);
      queue_ticks(300, 90);
      drain_ticks();

      // Reverse again, short bump periods racing qualification.
      new_setting(1'b1, BUMP_W'($urandom_range(40, 3)));
      queue_ticks(300, 80);
      drain_ticks();

      // Forward, medium bump period.
      new_setting(1'b0, BUMP_W'($urandom_range(300, 10)));
      queue_ticks(300, 60);
      drain_ticks();

      // Let any stray result show up before closing.
      repeat (8) @(posedge clock);

      $display("Ran %0d ticks under %0d csr settings (%0d csr writes).",
               ticks_sent, settings_run, csr_writes);
      $display("Checked %0d results: %0d commutations, %0d of them bumps.",
               results_seen, commutations_seen, bumps_seen);
      if (error_count == 0 && rsp_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
